// ----- rtl/bdlp_pkg.sv -----
// Shared types and constants of the button debouncer with long-press detection.
`timescale 1ns / 1ps

package bdlp_pkg;

    localparam int CNT_W = 17;
    localparam int REG_W = 16;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Register indexes, taken from paddr[2]
    localparam logic REG_DEBOUNCE_TICKS = 1'b0;
    localparam logic REG_LONG_PRESS_TICKS = 1'b1;

    localparam logic [REG_W-1:0] DEBOUNCE_TICKS_RST = 16'd50;
    localparam logic [REG_W-1:0] LONG_PRESS_TICKS_RST = 16'd1000;

    // Pin levels, active low button
    localparam logic LVL_PRESSED = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    typedef struct packed {
        logic [REG_W-1:0] debounce_ticks;
        logic [REG_W-1:0] long_press_ticks;
    } t_cfg;

    typedef struct packed {
        logic is_down;
        logic long_held;
        logic short_press_event;
        logic long_press_event;
    } t_result;

    // Count up, stick at all ones
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_MAX) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
        return r;
    endfunction

endpackage

// ----- rtl/bdlp_if.sv -----
// Valid/ready channel interfaces for tick samples and debounced results.
`timescale 1ns / 1ps

interface bdlp_in_if;
    logic valid;
    logic ready;
    logic raw_level;

    modport source(output valid, output raw_level, input ready);
    modport sink(input valid, input raw_level, output ready);
endinterface

interface bdlp_out_if;
    logic valid;
    logic ready;
    logic is_down;
    logic long_held;
    logic short_press_event;
    logic long_press_event;

    modport source(output valid, output is_down, output long_held,
                   output short_press_event, output long_press_event, input ready);
    modport sink(input valid, input is_down, input long_held,
                 input short_press_event, input long_press_event, output ready);
endinterface

// ----- rtl/bdlp_cfg.sv -----
// APB register file holding the debounce and long-press thresholds.
`timescale 1ns / 1ps

module bdlp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdlp_pkg::APB_AW-1:0]   paddr,
    input  logic [bdlp_pkg::APB_DW-1:0]   pwdata,
    output logic [bdlp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output bdlp_pkg::t_cfg                o_cfg
);

    bdlp_pkg::t_cfg r_cfg;
    logic           w_wr;
    logic           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= bdlp_pkg::DEBOUNCE_TICKS_RST;
            r_cfg.long_press_ticks <= bdlp_pkg::LONG_PRESS_TICKS_RST;
        end else if (w_wr) begin
            case (w_idx)
                bdlp_pkg::REG_DEBOUNCE_TICKS: begin
                    r_cfg.debounce_ticks <= pwdata[bdlp_pkg::REG_W-1:0];
                end
                bdlp_pkg::REG_LONG_PRESS_TICKS: begin
                    r_cfg.long_press_ticks <= pwdata[bdlp_pkg::REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            bdlp_pkg::REG_DEBOUNCE_TICKS: begin
                prdata = {{(bdlp_pkg::APB_DW-bdlp_pkg::REG_W){1'b0}}, r_cfg.debounce_ticks};
            end
            bdlp_pkg::REG_LONG_PRESS_TICKS: begin
                prdata = {{(bdlp_pkg::APB_DW-bdlp_pkg::REG_W){1'b0}},
                          r_cfg.long_press_ticks};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/bdlp_core.sv -----
// Per-tick debounce and hold tracking with a registered result stage.
`timescale 1ns / 1ps

module bdlp_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bdlp_pkg::t_cfg i_cfg,
    bdlp_in_if.sink        i_in,
    bdlp_out_if.source     o_out
);

    logic                         r_prev_raw;
    logic [bdlp_pkg::CNT_W-1:0]   r_stable_count;
    logic                         r_clean_level;
    logic [bdlp_pkg::CNT_W-1:0]   r_hold_count;
    logic                         r_long_flag;
    logic                         r_press_flag;
    logic                         r_out_valid;
    bdlp_pkg::t_result            r_out;

    logic [bdlp_pkg::CNT_W-1:0]   n_stable_count;
    logic                         n_clean_level;
    logic [bdlp_pkg::CNT_W-1:0]   n_hold_count;
    logic                         n_long_flag;
    logic                         n_press_flag;
    bdlp_pkg::t_result            n_out;
    logic                         w_settled;
    logic                         w_accept;

    // Take a new tick whenever the result stage is empty or being drained
    assign i_in.ready = ~r_out_valid | o_out.ready;
    assign w_accept   = i_in.valid & i_in.ready;

    always_comb begin
        n_stable_count = (i_in.raw_level != r_prev_raw) ? '0
                         : bdlp_pkg::sat_inc(r_stable_count);
        n_hold_count   = bdlp_pkg::sat_inc(r_hold_count);
        n_clean_level  = r_clean_level;
        n_long_flag    = r_long_flag;
        n_press_flag   = r_press_flag;
        n_out.short_press_event = 1'b0;
        n_out.long_press_event  = 1'b0;
        w_settled = n_stable_count > {1'b0, i_cfg.debounce_ticks};

        if (w_settled) begin
            if (i_in.raw_level != r_clean_level) begin
                n_clean_level = i_in.raw_level;
                if (i_in.raw_level == bdlp_pkg::LVL_PRESSED) begin
                    n_hold_count = '0;
                    n_press_flag = 1'b1;
                    n_long_flag  = 1'b0;
                end
            end
            if (n_clean_level == bdlp_pkg::LVL_PRESSED && !n_long_flag &&
                n_hold_count > {1'b0, i_cfg.long_press_ticks}) begin
                n_long_flag = 1'b1;
            end
            if (n_clean_level == bdlp_pkg::LVL_RELEASED && n_press_flag) begin
                n_out.long_press_event  = n_long_flag;
                n_out.short_press_event = ~n_long_flag;
                n_press_flag = 1'b0;
                n_long_flag  = 1'b0;
            end
        end

        n_out.is_down   = (n_clean_level == bdlp_pkg::LVL_PRESSED);
        n_out.long_held = (n_clean_level == bdlp_pkg::LVL_PRESSED) & n_long_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw     <= bdlp_pkg::LVL_RELEASED;
            r_stable_count <= '0;
            r_clean_level  <= bdlp_pkg::LVL_RELEASED;
            r_hold_count   <= '0;
            r_long_flag    <= 1'b0;
            r_press_flag   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_prev_raw     <= i_in.raw_level;
                r_stable_count <= n_stable_count;
                r_clean_level  <= n_clean_level;
                r_hold_count   <= n_hold_count;
                r_long_flag    <= n_long_flag;
                r_press_flag   <= n_press_flag;
                r_out_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.is_down           = r_out.is_down;
    assign o_out.long_held         = r_out.long_held;
    assign o_out.short_press_event = r_out.short_press_event;
    assign o_out.long_press_event  = r_out.long_press_event;

    a_long_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long_flag |-> (r_press_flag && r_clean_level == bdlp_pkg::LVL_PRESSED))
        else $error("long flag set without a held press");

    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(r_out.short_press_event && r_out.long_press_event))
        else $error("short and long release events together");

    a_event_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (r_out.short_press_event || r_out.long_press_event))
        |-> !r_out.is_down)
        else $error("release event while still pressed");

    a_bounce_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.raw_level != r_prev_raw) |=> (r_stable_count == '0))
        else $error("stability count not restarted on level change");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out.valid)
        else $error("accepted tick produced no result");

endmodule

// ----- rtl/button_debounce_long_press.sv -----
// Top level of the button debouncer with long-press detection.
`timescale 1ns / 1ps

// Button debouncer with long-press detection for an active-low push button.
// Each transfer on i_in is one tick (typically 1 ms) carrying the raw pin
// level, 0 pressed and 1 released; each tick yields exactly one transfer on
// o_out with the debounced state (is_down, long_held) and one-tick release
// pulses telling a short press from a long one. A raw level is accepted once
// it has been stable for more than debounce_ticks ticks; a press becomes long
// once held for more than long_press_ticks ticks. Both counters are 17 bits
// and saturate. A tick is taken every clock cycle: the whole state update is
// one pass of logic into the state registers and the result register, so the
// result is available in the cycle after the input transfer, and i_in stays
// ready while o_out holds a result as long as the sink takes it in the same
// cycle. Thresholds sit in an APB register file: debounce_ticks at byte
// address 0 (reset 50), long_press_ticks at 4 (reset 1000), low 16 bits used;
// write them only while no tick is in flight. pready is tied high.
module button_debounce_long_press (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bdlp_pkg::APB_AW-1:0]  paddr,
    input  logic [bdlp_pkg::APB_DW-1:0]  pwdata,
    output logic [bdlp_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    bdlp_in_if.sink                      i_in,
    bdlp_out_if.source                   o_out
);

    // Thresholds as seen by the tick logic
    bdlp_pkg::t_cfg w_cfg;

    bdlp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Debounce, hold timing and the result register
    bdlp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
